// ----- sv/vpc_pkg.sv -----
// Package for the video port command core: sizes, item kinds, access codes
// and the sequencer state type. No dependencies.
`default_nettype none
package vpc_pkg;
   // video RAM size in bytes; a power of two from 1024 to 65536
   localparam int VRAM_BYTES = 65536;
   localparam int VRAM_AW    = $clog2(VRAM_BYTES);

   localparam logic [1:0] KIND_CTRL_WR = 2'd0;
   localparam logic [1:0] KIND_DATA_WR = 2'd1;
   localparam logic [1:0] KIND_DATA_RD = 2'd2;
   localparam logic [1:0] KIND_STAT_RD = 2'd3;

   localparam logic [3:0] CODE_VRAM_WR = 4'h1;
   localparam logic [3:0] CODE_CRAM_WR = 4'h3;
   localparam logic [3:0] CODE_VSRAM_WR = 4'h5;
   localparam logic [3:0] CODE_VRAM_RD = 4'h0;
   localparam logic [3:0] CODE_CRAM_RD = 4'h8;
   localparam logic [3:0] CODE_VSRAM_RD = 4'h4;

   localparam logic [1:0] DMA_MODE_FILL = 2'b10;
   localparam logic [1:0] DMA_MODE_COPY = 2'b11;

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b00000000001,
      S_IDLE    = 11'b00000000010,
      S_EXEC    = 11'b00000000100,
      S_VWR2    = 11'b00000001000,
      S_VRD1    = 11'b00000010000,
      S_VRD2    = 11'b00000100000,
      S_AUXRD   = 11'b00001000000,
      S_FILL    = 11'b00010000000,
      S_COPY_RD = 11'b00100000000,
      S_COPY_WR = 11'b01000000000,
      S_SPARE   = 11'b10000000000
   } state_type;
endpackage
`default_nettype wire

// ----- sv/video_port_command_and_memory_access_core.sv -----
// Host control/data/status ports of a video chip with VRAM fill and copy.
// Items run in S_EXEC; VRAM writes go on through S_VWR2, VRAM reads through
// S_VRD1 and S_VRD2, aux reads through S_AUXRD. A fill writes one byte per
// S_FILL step, a copy runs S_COPY_RD then S_COPY_WR per byte. After reset a
// clearing pass over all VRAM_BYTES addresses zeroes the memories with busy
// high. The result strobe rsp_valid lasts one cycle and cannot be held off.
// Depends on vpc_pkg, vpc_vram, vpc_aux_ram.
`default_nettype none
module video_port_command_and_memory_access_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_bus_word,
   output logic             rsp_valid,
   output logic      [15:0] rsp_read_word,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);
   import vpc_pkg::*;

   state_type     state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [15:0]   word_ff, word_in;
   logic [15:0]   addr_ff, addr_in;
   logic [1:0]    top_ff, top_in;
   logic [5:0]    code_ff, code_in;
   logic          pend_ff, pend_in;
   logic          fill_ff, fill_in;
   logic          pal_ff;
   logic [7:0]    regs_ff [32];
   logic [7:0]    regs_in [32];
   logic [15:0]   src_ff, src_in;
   logic [16:0]   cnt_ff, cnt_in;
   logic [7:0]    hi_ff, hi_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_word_ff, rsp_word_in;
   logic [VRAM_AW-1:0] clr_ff, clr_in;

   logic               v_we, v_re;
   logic [VRAM_AW-1:0] v_wa, v_ra;
   logic [7:0]         v_wd, v_rd;
   logic               c_we, s_we, a_re;
   logic [5:0]         a_wa;
   logic [8:0]         c_wd, c_rd;
   logic [15:0]        s_wd, s_rd;

   logic [15:0] addr_step;
   logic [16:0] dma_len;
   logic [5:0]  code_new;
   logic [15:0] swapped;

   vpc_vram u_vram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_en(v_re), .rd_addr(v_ra), .rd_data(v_rd)
   );

   vpc_aux_ram u_aux (
      .clock(clock), .cram_wr_en(c_we), .vsram_wr_en(s_we), .wr_addr(a_wa),
      .cram_wr_data(c_wd), .vsram_wr_data(s_wd), .rd_en(a_re),
      .rd_addr(addr_ff[6:1]), .cram_rd_data(c_rd), .vsram_rd_data(s_rd)
   );

   // shared adder: every step of the port address addr_ff goes through here
   assign addr_step = addr_ff + {8'h00, regs_ff[15]};
   assign dma_len   = ({regs_ff[20], regs_ff[19]} == 16'h0000) ? 17'h10000
                      : {1'b0, regs_ff[20], regs_ff[19]};
   assign code_new  = {word_ff[7:4], code_ff[1:0]};
   assign swapped   = addr_ff[0] ? {word_ff[7:0], word_ff[15:8]} : word_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      word_in      = word_ff;
      addr_in      = addr_ff;
      top_in       = top_ff;
      code_in      = code_ff;
      pend_in      = pend_ff;
      fill_in      = fill_ff;
      regs_in      = regs_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;
      hi_in        = hi_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      clr_in       = clr_ff;
      v_we = 1'b0;
      v_wa = addr_ff[VRAM_AW-1:0];
      v_wd = 8'h00;
      v_re = 1'b0;
      v_ra = {addr_ff[VRAM_AW-1:1], 1'b0};
      c_we = 1'b0;
      s_we = 1'b0;
      a_wa = addr_ff[6:1];
      c_wd = {word_ff[3:1], word_ff[7:5], word_ff[11:9]};
      s_wd = word_ff;
      a_re = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            v_we   = 1'b1;
            v_wa   = clr_ff;
            a_wa   = clr_ff[5:0];
            c_wd   = 9'h000;
            s_wd   = 16'h0000;
            c_we   = (clr_ff[VRAM_AW-1:6] == '0);
            s_we   = (clr_ff[VRAM_AW-1:6] == '0);
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               word_in  = req_bus_word;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (kind_ff)
               KIND_CTRL_WR: begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = 16'h0000;
                  state_in     = S_IDLE;
                  if (!pend_ff) begin
                     if (word_ff[15:14] == 2'b10) begin
                        regs_in[word_ff[12:8]] = word_ff[7:0];
                     end else begin
                        pend_in = 1'b1;
                     end
                     addr_in = {top_ff, word_ff[13:0]};
                     code_in = {code_ff[5:2], word_ff[15:14]};
                  end else begin
                     pend_in = 1'b0;
                     addr_in = {word_ff[1:0], addr_ff[13:0]};
                     code_in = code_new;
                     top_in  = word_ff[1:0];
                     if (code_new[5] && regs_ff[1][4]) begin
                        if (regs_ff[23][7:6] == DMA_MODE_FILL) begin
                           fill_in = 1'b1;
                        end else if (regs_ff[23][7:6] == DMA_MODE_COPY) begin
                           src_in       = {regs_ff[22], regs_ff[21]};
                           cnt_in       = dma_len;
                           rsp_valid_in = 1'b0;
                           state_in     = S_COPY_RD;
                        end
                     end
                  end
               end
               KIND_DATA_WR: begin
                  pend_in = 1'b0;
                  if (fill_ff) begin
                     v_we     = 1'b1;
                     v_wd     = word_ff[7:0];
                     cnt_in   = dma_len;
                     state_in = S_FILL;
                  end else if (code_ff[3:0] == CODE_VRAM_WR) begin
                     v_we     = 1'b1;
                     v_wa     = {addr_ff[VRAM_AW-1:1], 1'b0};
                     v_wd     = swapped[15:8];
                     state_in = S_VWR2;
                  end else begin
                     c_we         = (code_ff[3:0] == CODE_CRAM_WR);
                     s_we         = (code_ff[3:0] == CODE_VSRAM_WR);
                     addr_in      = addr_step;
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = 16'h0000;
                     state_in     = S_IDLE;
                  end
               end
               KIND_DATA_RD: begin
                  pend_in = 1'b0;
                  if (code_ff[3:0] == CODE_VRAM_RD) begin
                     v_re     = 1'b1;
                     state_in = S_VRD1;
                  end else if (code_ff[3:0] == CODE_CRAM_RD ||
                               code_ff[3:0] == CODE_VSRAM_RD) begin
                     a_re     = 1'b1;
                     state_in = S_AUXRD;
                  end else begin
                     addr_in      = addr_step;
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = 16'h0000;
                     state_in     = S_IDLE;
                  end
               end
               KIND_STAT_RD: begin
                  pend_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = {12'h360, ~regs_ff[1][6], 2'b00, pal_ff};
                  state_in     = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_VWR2: begin
            v_we         = 1'b1;
            v_wa         = {addr_ff[VRAM_AW-1:1], 1'b1};
            v_wd         = swapped[7:0];
            addr_in      = addr_step;
            rsp_valid_in = 1'b1;
            rsp_word_in  = 16'h0000;
            state_in     = S_IDLE;
         end
         S_VRD1: begin
            hi_in    = v_rd;
            v_re     = 1'b1;
            v_ra     = {addr_ff[VRAM_AW-1:1], 1'b1};
            state_in = S_VRD2;
         end
         S_VRD2: begin
            addr_in      = addr_step;
            rsp_valid_in = 1'b1;
            rsp_word_in  = {hi_ff, v_rd};
            state_in     = S_IDLE;
         end
         S_AUXRD: begin
            addr_in      = addr_step;
            rsp_valid_in = 1'b1;
            rsp_word_in  = (code_ff[3:0] == CODE_CRAM_RD)
                           ? {4'h0, c_rd[2:0], 1'b0, c_rd[5:3], 1'b0, c_rd[8:6], 1'b0}
                           : s_rd;
            state_in     = S_IDLE;
         end
         S_FILL: begin
            v_we    = 1'b1;
            v_wa    = {addr_ff[VRAM_AW-1:1], ~addr_ff[0]};
            v_wd    = word_ff[15:8];
            addr_in = addr_step;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == 17'd1) begin
               regs_in[19]  = 8'h00;
               regs_in[20]  = 8'h00;
               fill_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_word_in  = 16'h0000;
               state_in     = S_IDLE;
            end
         end
         S_COPY_RD: begin
            v_re     = 1'b1;
            v_ra     = src_ff[VRAM_AW-1:0];
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            v_we    = 1'b1;
            v_wd    = v_rd;
            src_in  = src_ff + 16'd1;
            addr_in = addr_step;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == 17'd1) begin
               regs_in[19]  = 8'h00;
               regs_in[20]  = 8'h00;
               regs_in[21]  = src_in[7:0];
               regs_in[22]  = src_in[15:8];
               rsp_valid_in = 1'b1;
               rsp_word_in  = 16'h0000;
               state_in     = S_IDLE;
            end else begin
               state_in = S_COPY_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         addr_ff      <= 16'h0000;
         top_ff       <= 2'b00;
         code_ff      <= 6'h00;
         pend_ff      <= 1'b0;
         fill_ff      <= 1'b0;
         pal_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 32; i++) begin
            regs_ff[i] <= (i == 10) ? 8'hFF : 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         addr_ff      <= addr_in;
         top_ff       <= top_in;
         code_ff      <= code_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
         if (csr_wr_en) begin
            pal_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      word_ff     <= word_in;
      src_ff      <= src_in;
      cnt_ff      <= cnt_in;
      hi_ff       <= hi_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = rsp_word_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> !rsp_valid) else $error("result during clear pass");
   a_dma_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL || state_ff == S_COPY_WR) |-> (cnt_ff != 17'd0))
      else $error("dma count underflow");
endmodule
`default_nettype wire

// ----- sv/vpc_vram.sv -----
// Video RAM: byte wide, one write port and one registered read port.
// Depends on vpc_pkg.
`default_nettype none
module vpc_vram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [vpc_pkg::VRAM_AW-1:0] wr_addr,
   input  wire logic [7:0]                 wr_data,
   input  wire logic                       rd_en,
   input  wire logic [vpc_pkg::VRAM_AW-1:0] rd_addr,
   output logic      [7:0]                 rd_data
);
   import vpc_pkg::*;

   logic [7:0] mem [VRAM_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- sv/vpc_aux_ram.sv -----
// Color RAM (64 x 9) and scroll RAM (64 x 16), shared address, registered reads.
// Depends on vpc_pkg.
`default_nettype none
module vpc_aux_ram (
   input  wire logic        clock,
   input  wire logic        cram_wr_en,
   input  wire logic        vsram_wr_en,
   input  wire logic [5:0]  wr_addr,
   input  wire logic [8:0]  cram_wr_data,
   input  wire logic [15:0] vsram_wr_data,
   input  wire logic        rd_en,
   input  wire logic [5:0]  rd_addr,
   output logic      [8:0]  cram_rd_data,
   output logic      [15:0] vsram_rd_data
);
   import vpc_pkg::*;

   logic [8:0]  cram [64];
   logic [15:0] vsram [64];
   logic [8:0]  cram_rd_ff;
   logic [15:0] vsram_rd_ff;

   always_ff @(posedge clock) begin
      if (cram_wr_en) begin
         cram[wr_addr] <= cram_wr_data;
      end
      if (vsram_wr_en) begin
         vsram[wr_addr] <= vsram_wr_data;
      end
      if (rd_en) begin
         cram_rd_ff  <= cram[rd_addr];
         vsram_rd_ff <= vsram[rd_addr];
      end
   end

   assign cram_rd_data  = cram_rd_ff;
   assign vsram_rd_data = vsram_rd_ff;
endmodule
`default_nettype wire

// ----- sim/tb_video_port_command_and_memory_access_core.sv -----
// Testbench for the video port command core: directed table plus random
// command sequences, checked against an in-bench predictor. Depends on vpc_pkg.
`timescale 1ns / 100ps
module tb_video_port_command_and_memory_access_core;
   import vpc_pkg::*;

   localparam int IDLE_LIMIT  = 400000;
   localparam int ITEM_TARGET = 1950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_STAT_RD;
   logic [15:0] req_bus_word = 16'h0000;
   logic        rsp_valid;
   logic [15:0] rsp_read_word;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   video_port_command_and_memory_access_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_bus_word(req_bus_word),
      .rsp_valid(rsp_valid), .rsp_read_word(rsp_read_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // predicted chip state
   logic [7:0]  vram_m [VRAM_BYTES];
   logic [8:0]  cram_m [64];
   logic [15:0] vsram_m [64];
   logic [7:0]  regs_m [32];
   logic [15:0] addr_m;
   logic [1:0]  top_m;
   logic [5:0]  code_m;
   logic        pending_m;
   logic        fill_m;
   logic        pal_m;

   logic [15:0] read_words_due[$];
   int          errors = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 1'b0;

   function automatic int vix(logic [31:0] a);
      return int'(a[15:0]) % VRAM_BYTES;
   endfunction

   function automatic logic [31:0] dma_len();
      logic [15:0] n;
      n = {regs_m[20], regs_m[19]};
      return (n == 16'h0) ? 32'h10000 : {16'h0, n};
   endfunction

   function automatic logic [15:0] predict_read_word(logic [1:0] k, logic [15:0] w);
      logic [15:0] r;
      logic [15:0] d;
      logic [15:0] src;
      logic [8:0]  p;
      logic [31:0] n;
      r = 16'h0;
      case (k)
         KIND_CTRL_WR: begin
            if (!pending_m) begin
               if (w[15:14] == 2'b10) regs_m[w[12:8]] = w[7:0];
               else pending_m = 1'b1;
               addr_m = {top_m, w[13:0]};
               code_m = {code_m[5:2], w[15:14]};
            end else begin
               pending_m = 1'b0;
               addr_m = {w[1:0], addr_m[13:0]};
               code_m = {w[7:4], code_m[1:0]};
               top_m = addr_m[15:14];
               if (code_m[5] && regs_m[1][4]) begin
                  if (regs_m[23][7:6] == DMA_MODE_FILL) fill_m = 1'b1;
                  else if (regs_m[23][7:6] == DMA_MODE_COPY) begin
                     n = dma_len();
                     src = {regs_m[22], regs_m[21]};
                     for (int i = 0; i < n; i++) begin
                        vram_m[vix(addr_m)] = vram_m[vix(src)];
                        src = src + 16'd1;
                        addr_m = addr_m + regs_m[15];
                     end
                     regs_m[19] = 8'h0;
                     regs_m[20] = 8'h0;
                     regs_m[21] = src[7:0];
                     regs_m[22] = src[15:8];
                  end
               end
            end
         end
         KIND_DATA_WR: begin
            pending_m = 1'b0;
            if (fill_m) begin
               n = dma_len();
               vram_m[vix(addr_m)] = w[7:0];
               for (int i = 0; i < n; i++) begin
                  vram_m[vix(addr_m ^ 16'h1)] = w[15:8];
                  addr_m = addr_m + regs_m[15];
               end
               regs_m[19] = 8'h0;
               regs_m[20] = 8'h0;
               fill_m = 1'b0;
            end else begin
               case (code_m[3:0])
                  CODE_VRAM_WR: begin
                     d = addr_m[0] ? {w[7:0], w[15:8]} : w;
                     vram_m[vix({addr_m[15:1], 1'b0})] = d[15:8];
                     vram_m[vix({addr_m[15:1], 1'b0} + 32'd1)] = d[7:0];
                  end
                  CODE_CRAM_WR: cram_m[addr_m[6:1]] = {w[3:1], w[7:5], w[11:9]};
                  CODE_VSRAM_WR: vsram_m[addr_m[6:1]] = w;
                  default: ;
               endcase
               addr_m = addr_m + regs_m[15];
            end
         end
         KIND_DATA_RD: begin
            pending_m = 1'b0;
            case (code_m[3:0])
               CODE_VRAM_RD: r = {vram_m[vix({addr_m[15:1], 1'b0})],
                                  vram_m[vix({addr_m[15:1], 1'b0} + 32'd1)]};
               CODE_CRAM_RD: begin
                  p = cram_m[addr_m[6:1]];
                  r = {4'h0, p[2:0], 1'b0, p[5:3], 1'b0, p[8:6], 1'b0};
               end
               CODE_VSRAM_RD: r = vsram_m[addr_m[6:1]];
               default: ;
            endcase
            addr_m = addr_m + regs_m[15];
         end
         default: begin
            r = 16'h3600 | {15'h0, pal_m};
            if (!regs_m[1][6]) r = r | 16'h0008;
            pending_m = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // one item: optional gap, drive, wait for acceptance, record expectation
   task automatic send_item(input logic [1:0] k, input logic [15:0] w,
                            input bit has_lit = 1'b0, input logic [15:0] lit = 16'h0);
      int          gap;
      logic [15:0] p;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= k;
      req_bus_word <= w;
      do @(posedge clock); while (busy);
      p = predict_read_word(k, w);
      read_words_due.push_back(has_lit ? lit : p);
      items_sent++;
   endtask

   task automatic write_mode_reg(input logic [4:0] r, input logic [7:0] v);
      send_item(KIND_CTRL_WR, {2'b10, 1'($urandom), r, v});
   endtask

   task automatic send_command(input logic [5:0] c, input logic [15:0] a);
      send_item(KIND_CTRL_WR, {c[1:0], a[13:0]});
      send_item(KIND_CTRL_WR, {8'($urandom), c[5:2], 2'($urandom), a[15:14]});
   endtask

   // wait for every result, let the block settle, then write pal_mode
   task automatic set_pal(input logic v);
      start <= 1'b0;
      wait (read_words_due.size() == 0);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pal_m = v;
   endtask

   always @(posedge clock) begin
      if (rsp_valid) begin
         if (read_words_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual read_word %h",
                     $time, rsp_read_word);
            errors++;
         end else begin
            if (rsp_read_word !== read_words_due[0]) begin
               $display("%0t: read_word mismatch, expected %h, actual %h",
                        $time, read_words_due[0], rsp_read_word);
               errors++;
            end
            void'(read_words_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] word;
      bit          has_lit;
      logic [15:0] lit;
   } row_type;

   localparam int N_ROWS = 35;
   row_type rows [N_ROWS] = '{
      '{KIND_STAT_RD, 16'hFFFF, 1, 16'h3608},   // after reset: display off
      '{KIND_DATA_RD, 16'h0000, 1, 16'h0000},
      '{KIND_CTRL_WR, 16'h8144, 0, 0},          // display enable
      '{KIND_STAT_RD, 16'h0000, 1, 16'h3600},
      '{KIND_CTRL_WR, 16'h8F02, 0, 0},          // increment 2
      '{KIND_CTRL_WR, 16'h7FFE, 0, 0},          // VRAM write at 0xFFFE
      '{KIND_CTRL_WR, 16'h0003, 0, 0},
      '{KIND_DATA_WR, 16'hFFFF, 0, 0},
      '{KIND_DATA_WR, 16'h0000, 0, 0},          // address wraps to 0
      '{KIND_CTRL_WR, 16'h3FFE, 0, 0},          // VRAM read at 0xFFFE
      '{KIND_CTRL_WR, 16'h0003, 0, 0},
      '{KIND_DATA_RD, 16'h0000, 1, 16'hFFFF},
      '{KIND_DATA_RD, 16'hFFFF, 1, 16'h0000},
      '{KIND_CTRL_WR, 16'h4001, 0, 0},          // odd address: bytes swap
      '{KIND_CTRL_WR, 16'h0000, 0, 0},
      '{KIND_DATA_WR, 16'h1234, 0, 0},
      '{KIND_CTRL_WR, 16'hC000, 0, 0},          // CRAM write
      '{KIND_CTRL_WR, 16'h0000, 0, 0},
      '{KIND_DATA_WR, 16'hFFFF, 0, 0},
      '{KIND_CTRL_WR, 16'h0000, 0, 0},          // CRAM read
      '{KIND_CTRL_WR, 16'h0020, 0, 0},
      '{KIND_DATA_RD, 16'h0000, 1, 16'h0EEE},
      '{KIND_CTRL_WR, 16'h4000, 0, 0},          // pending first word...
      '{KIND_STAT_RD, 16'h0000, 1, 16'h3600},   // ...cleared by status
      '{KIND_CTRL_WR, 16'hC000, 0, 0},          // unused code 0x0F
      '{KIND_CTRL_WR, 16'h0030, 0, 0},
      '{KIND_DATA_WR, 16'h5555, 0, 0},
      '{KIND_DATA_RD, 16'h0000, 1, 16'h0000},
      '{KIND_CTRL_WR, 16'h8154, 0, 0},          // DMA on, fill mode, length 0
      '{KIND_CTRL_WR, 16'h9780, 0, 0},
      '{KIND_CTRL_WR, 16'h8F01, 0, 0},
      '{KIND_CTRL_WR, 16'h4000, 0, 0},
      '{KIND_CTRL_WR, 16'h0080, 0, 0},
      '{KIND_DATA_WR, 16'hABCD, 0, 0},          // full 64K fill
      '{KIND_CTRL_WR, 16'h9740, 0, 0}           // bus DMA mode: ignored
   };

   initial begin
      int          scen;
      int          reps;
      logic [4:0]  r;
      logic [15:0] w;
      for (int i = 0; i < VRAM_BYTES; i++) vram_m[i] = 8'h0;
      for (int i = 0; i < 64; i++) begin
         cram_m[i] = 9'h0;
         vsram_m[i] = 16'h0;
      end
      for (int i = 0; i < 32; i++) regs_m[i] = 8'h0;
      regs_m[10] = 8'hFF;
      addr_m = 16'h0;
      top_m = 2'b00;
      code_m = 6'h0;
      pending_m = 1'b0;
      fill_m = 1'b0;
      pal_m = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_pal(1'b0);
      for (int i = 0; i < N_ROWS; i++)
         send_item(rows[i].kind, rows[i].word, rows[i].has_lit, rows[i].lit);
      // bus DMA request does nothing; then a full 64K copy
      send_command(6'h20, 16'h0100);
      write_mode_reg(5'd23, 8'hC0);
      write_mode_reg(5'd21, 8'h00);
      write_mode_reg(5'd22, 8'h80);
      send_command(6'h20, 16'h0000);
      send_item(KIND_STAT_RD, 16'h0000);
      set_pal(1'b1);
      send_item(KIND_STAT_RD, 16'h0000);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent % 650 < 10 && items_sent > 100) set_pal(~pal_m);
         no_gaps = ($urandom_range(0, 7) == 0);
         send_item(KIND_STAT_RD, 16'($urandom));
         scen = $urandom_range(0, 9);
         case (scen)
            0, 1: begin
               reps = $urandom_range(1, 3);
               for (int i = 0; i < reps; i++) begin
                  r = 5'($urandom);
                  if (r == 5'd19) write_mode_reg(r, 8'($urandom_range(1, 40)));
                  else if (r == 5'd20) write_mode_reg(r, 8'h00);
                  else write_mode_reg(r, 8'($urandom));
               end
            end
            2, 3, 4: begin
               // plain access run with a valid code
               case ($urandom_range(0, 5))
                  0: send_command(6'h01, 16'($urandom));
                  1: send_command(6'h03, 16'($urandom));
                  2: send_command(6'h05, 16'($urandom));
                  3: send_command(6'h00, 16'($urandom));
                  4: send_command(6'h08, 16'($urandom));
                  default: send_command(6'h04, 16'($urandom));
               endcase
               reps = $urandom_range(1, 6);
               for (int i = 0; i < reps; i++)
                  send_item($urandom_range(0, 1) ? KIND_DATA_WR : KIND_DATA_RD,
                            16'($urandom));
            end
            5: begin
               // DMA enable is bit 4 of register 1
               write_mode_reg(5'd1, {1'($urandom), 1'($urandom), 1'($urandom), 1'b1,
                                     4'($urandom)});
               write_mode_reg(5'd23, {2'b10, 6'($urandom)});
               write_mode_reg(5'd19, 8'($urandom_range(1, 40)));
               write_mode_reg(5'd20, 8'h00);
               write_mode_reg(5'd15, 8'($urandom_range(0, 4)));
               send_command({1'b1, 4'($urandom), 1'b1}, 16'($urandom));
               send_item(KIND_DATA_WR, 16'($urandom));
               send_command(6'h00, addr_m - 16'd8);
               reps = $urandom_range(2, 6);
               for (int i = 0; i < reps; i++) send_item(KIND_DATA_RD, 16'($urandom));
            end
            6: begin
               write_mode_reg(5'd1, {1'($urandom), 1'($urandom), 1'($urandom), 1'b1,
                                     4'($urandom)});
               write_mode_reg(5'd23, {2'b11, 6'($urandom)});
               write_mode_reg(5'd21, 8'($urandom));
               write_mode_reg(5'd22, 8'($urandom));
               write_mode_reg(5'd19, 8'($urandom_range(1, 40)));
               write_mode_reg(5'd20, 8'h00);
               send_command({1'b1, 5'($urandom)}, 16'($urandom));
               send_command(6'h00, addr_m - 16'd4);
               reps = $urandom_range(1, 4);
               for (int i = 0; i < reps; i++) send_item(KIND_DATA_RD, 16'($urandom));
            end
            default: begin
               reps = $urandom_range(1, 5);
               for (int i = 0; i < reps; i++) begin
                  w = 16'($urandom);
                  scen = $urandom_range(0, 3);
                  // keep noise from starting a DMA
                  if (scen == 0) w[7] = 1'b0;
                  send_item(2'(scen), w);
               end
            end
         endcase
      end
      start <= 1'b0;
      set_pal(1'b0);
      wait (read_words_due.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/vpc_pkg.sv
sv/vpc_vram.sv
sv/vpc_aux_ram.sv
sv/video_port_command_and_memory_access_core.sv
sim/tb_video_port_command_and_memory_access_core.sv
